// ===== rtl/pidc_pkg.sv =====
`timescale 1ns / 1ps

package pidc_pkg;

    localparam int CFG_DATA_W = 20;
    localparam int CFG_ADDR_W = 3;

    localparam int ERR_W  = 17;
    localparam int DIFF_W = 18;
    localparam int ACC_W  = 21;
    localparam int P_W    = 33;
    localparam int I_W    = 37;
    localparam int D_W    = 34;
    localparam int SUM_W  = 39;
    localparam int MAG_W  = 32;
    localparam int Q_W    = 17;

    // Quotient magnitude that behaves like any larger one under the output clamp.
    localparam logic [15:0] Q_SAT = 16'd32769;

    // Reciprocal of ten for operands below 2**26: q = (m * DIV10_RECIP) >> DIV10_SHIFT.
    localparam logic [23:0] DIV10_RECIP = 24'd13421773;
    localparam int          DIV10_SHIFT = 27;

    localparam logic [CFG_ADDR_W-1:0] REG_P_COEF          = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_I_COEF          = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_D_COEF          = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ERROR_DEADBAND  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INT_RESET_LIMIT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEGRAL_LIMIT  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_MIN      = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_MAX      = 3'd7;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] measured;
        logic signed [15:0] setpoint;
        logic               run_enabled;
    } pidc_in_t;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               in_deadband;
    } pidc_out_t;

    typedef struct packed {
        logic signed [15:0] p_coef;
        logic signed [15:0] i_coef;
        logic signed [15:0] d_coef;
        logic signed [16:0] error_deadband;
        logic signed [17:0] int_reset_limit;
        logic        [19:0] integral_limit;
        logic signed [15:0] output_min;
        logic signed [15:0] output_max;
    } pidc_cfg_t;

    typedef struct packed {
        logic live;
        logic dead;
    } pidc_flags_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [ACC_W-1:0]  acc;
        logic signed [DIFF_W-1:0] dterm;
        pidc_flags_t              flags;
    } pidc_s1_t;

    typedef struct packed {
        logic signed [P_W-1:0] p_term;
        logic signed [I_W-1:0] i_term;
        logic signed [D_W-1:0] d_term;
        pidc_flags_t           flags;
    } pidc_s2_t;

endpackage

// ===== rtl/pidc_state.sv =====
`timescale 1ns / 1ps

module pidc_state #(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  pidc_pkg::pidc_in_t  in_data,
    input  pidc_pkg::pidc_cfg_t cfg,
    output pidc_pkg::pidc_s1_t  s1
);
    import pidc_pkg::*;

    logic signed [ERR_W-1:0]  hist_reg [HISTORY_DEPTH];
    logic signed [ACC_W-1:0]  integral_reg;
    pidc_s1_t                 s1_reg;

    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] dterm;
    logic signed [18:0]       err_x;
    logic signed [18:0]       db_x;
    logic signed [18:0]       neg_db;
    logic                     active;
    logic [19:0]              acc_mag;
    logic [23:0]              acc_x9;
    logic [47:0]              div_prod;
    logic [19:0]              decay_mag;
    logic signed [ACC_W-1:0]  decayed;
    logic signed [21:0]       pre;
    logic signed [19:0]       diff_x;
    logic signed [19:0]       rl_x;
    logic signed [19:0]       neg_rl;
    logic                     step_reset;
    logic signed [21:0]       lim_x;
    logic signed [21:0]       neg_lim;
    logic signed [21:0]       clamped;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     clear;

    assign clear = in_data.req_type;

    always_comb
    begin
        err   = {in_data.setpoint[15], in_data.setpoint} - {in_data.measured[15], in_data.measured};
        diff  = {err[ERR_W-1], err} - {hist_reg[0][ERR_W-1], hist_reg[0]};
        dterm = {err[ERR_W-1], err}
              - {hist_reg[HISTORY_DEPTH-1][ERR_W-1], hist_reg[HISTORY_DEPTH-1]};

        err_x  = {{2{err[ERR_W-1]}}, err};
        db_x   = {{2{cfg.error_deadband[16]}}, cfg.error_deadband};
        neg_db = -db_x;
        active = (cfg.error_deadband == '1) || (err_x > db_x) || (err_x < neg_db);

        acc_mag   = integral_reg[ACC_W-1] ? 20'(-integral_reg) : 20'(integral_reg);
        acc_x9    = {1'b0, acc_mag, 3'b000} + {4'b0000, acc_mag};
        div_prod  = {24'd0, acc_x9} * {24'd0, DIV10_RECIP};
        decay_mag = div_prod[DIV10_SHIFT +: 20];
        decayed   = integral_reg[ACC_W-1] ? -$signed({1'b0, decay_mag})
                                          : $signed({1'b0, decay_mag});

        if (err == '0)
        begin
            pre = {decayed[ACC_W-1], decayed};
        end
        else if (in_data.run_enabled)
        begin
            pre = {integral_reg[ACC_W-1], integral_reg}
                + {{5{err[ERR_W-1]}}, err};
        end
        else
        begin
            pre = {integral_reg[ACC_W-1], integral_reg};
        end

        diff_x     = {{2{diff[DIFF_W-1]}}, diff};
        rl_x       = {{2{cfg.int_reset_limit[17]}}, cfg.int_reset_limit};
        neg_rl     = -rl_x;
        step_reset = (cfg.int_reset_limit != '1) && ((diff_x > rl_x) || (diff_x < neg_rl));

        lim_x   = {2'b00, cfg.integral_limit};
        neg_lim = -lim_x;

        if (step_reset)
        begin
            clamped = '0;
        end
        else if (pre > lim_x)
        begin
            clamped = lim_x;
        end
        else if (pre < neg_lim)
        begin
            clamped = neg_lim;
        end
        else
        begin
            clamped = pre;
        end
        acc_next = clamped[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (load)
        begin
            if (clear)
            begin
                integral_reg <= '0;
                for (int i = 0; i < HISTORY_DEPTH; i++)
                begin
                    hist_reg[i] <= '0;
                end
            end
            else
            begin
                if (active)
                begin
                    integral_reg <= acc_next;
                end
                for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0] <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_reg.err        <= err;
            s1_reg.acc        <= acc_next;
            s1_reg.dterm      <= dterm;
            s1_reg.flags.live <= !clear && active;
            s1_reg.flags.dead <= !clear && !active;
        end
    end

    assign s1 = s1_reg;

    // A clear transaction leaves the integral and the newest history entry at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        load && clear |=> integral_reg == '0 && hist_reg[0] == '0)
        else $error("integral or history not cleared");

    // A step inside the deadband leaves the integral untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        load && !clear && !active |=> integral_reg == $past(integral_reg))
        else $error("integral changed inside the deadband");

endmodule

// ===== rtl/pidc_terms.sv =====
`timescale 1ns / 1ps

module pidc_terms (
    input  logic                clk,
    input  logic                load,
    input  pidc_pkg::pidc_s1_t  s1,
    input  pidc_pkg::pidc_cfg_t cfg,
    output pidc_pkg::pidc_s2_t  s2
);
    import pidc_pkg::*;

    logic signed [ERR_W-1:0]  err_s;
    logic signed [ACC_W-1:0]  acc_s;
    logic signed [DIFF_W-1:0] dterm_s;
    logic signed [15:0]       kp;
    logic signed [15:0]       ki;
    logic signed [15:0]       kd;
    logic signed [P_W-1:0]    p_prod;
    logic signed [I_W-1:0]    i_prod;
    logic signed [D_W-1:0]    d_prod;
    pidc_s2_t                 s2_reg;

    assign err_s   = s1.err;
    assign acc_s   = s1.acc;
    assign dterm_s = s1.dterm;
    assign kp      = cfg.p_coef;
    assign ki      = cfg.i_coef;
    assign kd      = cfg.d_coef;

    assign p_prod = kp * err_s;
    assign i_prod = ki * acc_s;
    assign d_prod = kd * dterm_s;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_reg.p_term <= p_prod;
            s2_reg.i_term <= i_prod;
            s2_reg.d_term <= d_prod;
            s2_reg.flags  <= s1.flags;
        end
    end

    assign s2 = s2_reg;

endmodule

// ===== rtl/pidc_scale.sv =====
`timescale 1ns / 1ps

module pidc_scale #(
    parameter int SCALE_DIVISOR = 16
) (
    input  logic                clk,
    input  logic                load_sum,
    input  logic                load_out,
    input  pidc_pkg::pidc_s2_t  s2,
    input  pidc_pkg::pidc_cfg_t cfg,
    output pidc_pkg::pidc_out_t out_data
);
    import pidc_pkg::*;

    localparam int DIV_LOG = $clog2(SCALE_DIVISOR);
    localparam int SHIFT   = MAG_W + DIV_LOG;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(SCALE_DIVISOR) - 64'd1) / 64'(SCALE_DIVISOR);
    localparam logic [MAG_W:0] RECIP = RECIP_FULL[MAG_W:0];
    localparam logic [SUM_W-1:0] SAT_LIM = SUM_W'(SCALE_DIVISOR) * SUM_W'(Q_SAT);

    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]         sum_mag;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic                     big_reg;
    pidc_flags_t              flags_reg;

    logic [2*MAG_W:0]         quot_prod;
    logic [15:0]              q_mag;
    logic signed [Q_W-1:0]    q;
    logic signed [Q_W-1:0]    min_x;
    logic signed [Q_W-1:0]    max_x;
    logic signed [Q_W-1:0]    low_clamped;
    logic signed [Q_W-1:0]    both_clamped;
    pidc_out_t                out_reg;

    always_comb
    begin
        sum = {{(SUM_W-P_W){s2.p_term[P_W-1]}}, s2.p_term}
            + {{(SUM_W-I_W){s2.i_term[I_W-1]}}, s2.i_term}
            - {{(SUM_W-D_W){s2.d_term[D_W-1]}}, s2.d_term};
        sum_mag = sum[SUM_W-1] ? -sum : sum;
    end

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            mag_reg   <= sum_mag[MAG_W-1:0];
            neg_reg   <= sum[SUM_W-1];
            big_reg   <= sum_mag >= SAT_LIM;
            flags_reg <= s2.flags;
        end
    end

    always_comb
    begin
        quot_prod = {{(MAG_W+1){1'b0}}, mag_reg} * {{MAG_W{1'b0}}, RECIP};
        q_mag     = big_reg ? Q_SAT : quot_prod[SHIFT +: 16];
        q         = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        min_x     = {cfg.output_min[15], cfg.output_min};
        max_x     = {cfg.output_max[15], cfg.output_max};
        low_clamped  = (q < min_x) ? min_x : q;
        both_clamped = (low_clamped > max_x) ? max_x : low_clamped;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.drive       <= flags_reg.live ? both_clamped[15:0] : 16'sd0;
            out_reg.in_deadband <= flags_reg.dead;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/pid_controller_deadband_antiwindup.sv =====
`timescale 1ns / 1ps

// PID controller with deadband, integral reset on error steps and anti-windup clamp.
// Input channel: in_valid, in_stall, in_data (req_type, measured, setpoint, run_enabled).
// A transaction with req_type set clears the integral and error history and
// returns drive 0 with in_deadband 0; any other transaction is one control step.
// Output channel: out_valid, out_stall, out_data (drive, in_deadband); exactly one
// result per input transaction, in order.
// There are four register stages: a transaction accepted into the first has its
// result on out_valid once it reaches the fourth.
// Throughput is one transaction per cycle while out_stall is low: the integral and
// error history are updated in the first stage, so the next step already sees them;
// the three gain multiplies share the second stage, the sum takes the third and the
// reciprocal divide by SCALE_DIVISOR the fourth.
// When out_stall is high the stages fill up behind the result register, and
// in_stall rises once the first stage holds a transaction that cannot move.
// Reset clears the valid bits, the integral, the history and all configuration
// registers to their defaults; no clearing pass follows. Configuration is written
// via cfg_we, cfg_addr and cfg_wdata only while idle, which the user must ensure.
module pid_controller_deadband_antiwindup #(
    parameter int HISTORY_DEPTH = 4,
    parameter int SCALE_DIVISOR = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  pidc_pkg::pidc_in_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output pidc_pkg::pidc_out_t                   out_data,
    input  logic                                  cfg_we,
    input  logic [pidc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import pidc_pkg::*;

    pidc_cfg_t cfg_reg;
    logic      v1_reg;
    logic      v2_reg;
    logic      v3_reg;
    logic      v4_reg;
    logic      ready1;
    logic      ready2;
    logic      ready3;
    logic      ready4;
    logic      load1;
    logic      load2;
    logic      load3;
    logic      load4;
    pidc_s1_t  s1;
    pidc_s2_t  s2;

    assign ready4 = !v4_reg || !out_stall;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign load1  = in_valid && ready1;
    assign load2  = v1_reg && ready2;
    assign load3  = v2_reg && ready3;
    assign load4  = v3_reg && ready4;

    assign in_stall  = !ready1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.p_coef          <= '0;
            cfg_reg.i_coef          <= '0;
            cfg_reg.d_coef          <= '0;
            cfg_reg.error_deadband  <= '1;
            cfg_reg.int_reset_limit <= '1;
            cfg_reg.integral_limit  <= '1;
            cfg_reg.output_min      <= 16'sh8000;
            cfg_reg.output_max      <= 16'sh7FFF;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_P_COEF:          cfg_reg.p_coef          <= cfg_wdata[15:0];
                REG_I_COEF:          cfg_reg.i_coef          <= cfg_wdata[15:0];
                REG_D_COEF:          cfg_reg.d_coef          <= cfg_wdata[15:0];
                REG_ERROR_DEADBAND:  cfg_reg.error_deadband  <= cfg_wdata[16:0];
                REG_INT_RESET_LIMIT: cfg_reg.int_reset_limit <= cfg_wdata[17:0];
                REG_INTEGRAL_LIMIT:  cfg_reg.integral_limit  <= cfg_wdata[19:0];
                REG_OUTPUT_MIN:      cfg_reg.output_min      <= cfg_wdata[15:0];
                REG_OUTPUT_MAX:      cfg_reg.output_max      <= cfg_wdata[15:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    pidc_state #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load1),
        .in_data(in_data),
        .cfg    (cfg_reg),
        .s1     (s1)
    );

    pidc_terms u_terms (
        .clk (clk),
        .load(load2),
        .s1  (s1),
        .cfg (cfg_reg),
        .s2  (s2)
    );

    pidc_scale #(
        .SCALE_DIVISOR(SCALE_DIVISOR)
    ) u_scale (
        .clk     (clk),
        .load_sum(load3),
        .load_out(load4),
        .s2      (s2),
        .cfg     (cfg_reg),
        .out_data(out_data)
    );

    // With the receiver taking results, the pipeline never pushes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output drains");

    // A result inside the deadband carries a zero drive.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.in_deadband |-> out_data.drive == '0)
        else $error("nonzero drive inside the deadband");

endmodule
